@@ design/frame_tween_slot_manager_defines.svh @@
// assertion macros for the frame tween slot manager checker
`ifndef FRAME_TWEEN_SLOT_MANAGER_DEFINES_SVH
`define FRAME_TWEEN_SLOT_MANAGER_DEFINES_SVH

// same-cycle implication
`define FTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fts_pkg.sv @@
// shared types and constants of the frame tween slot manager
package fts_pkg;

    localparam int DEF_SLOTS      = 8;
    localparam int DEF_FRAME_BITS = 16;
    localparam int Q_FRAC         = 16;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 16;
    localparam int EV_W    = 2;
    localparam int PROG_W  = 17;

    localparam logic [PROG_W-1:0] PROG_ONE = 17'h10000;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_FINISH = 2'd3
    } kind_t;

    typedef enum logic [EV_W-1:0] {
        EV_GRANT    = 2'd0,
        EV_PROGRESS = 2'd1,
        EV_FINISHED = 2'd2
    } ev_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] frame_count;
        logic               notify_on_finish;
    } cmd_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  owner_tag;
        logic [PROG_W-1:0] progress;
        logic              last;
    } evt_t;

endpackage

@@ design/fts_stream_if.sv @@
// valid/ready stream channel carrying one payload per transfer
interface fts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/fts_divider.sv @@
// serial restoring divider giving the fractional quotient of numer/denom, numer < denom
module fts_divider import fts_pkg::*; #(
    parameter int FRAME_BITS = DEF_FRAME_BITS,
    parameter int Q_BITS     = Q_FRAC
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAME_BITS-1:0] numer,
    input  logic [FRAME_BITS-1:0] denom,
    output logic                  done,
    output logic [Q_BITS-1:0]     quot
);

    localparam int CNT_W = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_BITS - 1);

    logic [FRAME_BITS-1:0] rem_reg, rem_next;
    logic [FRAME_BITS-1:0] denom_reg, denom_next;
    logic [Q_BITS-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [FRAME_BITS:0] shifted;
    logic [FRAME_BITS:0] diff;
    logic                ge;

    always_comb
    begin
        shifted    = {rem_reg, 1'b0};
        diff       = shifted - {1'b0, denom_reg};
        ge         = shifted >= {1'b0, denom_reg};
        rem_next   = rem_reg;
        denom_next = denom_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = numer;
            denom_next = denom;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[FRAME_BITS-1:0] : shifted[FRAME_BITS-1:0];
            quot_next = {quot_reg[Q_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            denom_reg <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            denom_reg <= denom_next;
            quot_reg  <= quot_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ design/frame_tween_slot_manager.sv @@
// top level of the frame tween slot manager: slot memory, sequencer and result register
//
// channel  direction  payload
// cmd      in         kind, slot, tag, frame_count, notify_on_finish
// evt      out        event_res, slot_index, owner_tag, progress, last
//
// tick: an active slot short of its total is divided by the serial divider (one quotient bit
//   per cycle), free slots are skipped; start on a full bank first scans every slot and reclaims one
// stop and finish free the named slot; one item is in work at a time
// reset clears the slot busy bits at once, no memory clearing pass
// a result waits in the output register; the sequencer stalls only when it holds one
module frame_tween_slot_manager import fts_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    fts_stream_if.sink   cmd,
    fts_stream_if.source evt
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = 2 * FRAME_BITS + TAG_W + 1;
    localparam int TAG_LO  = 1;
    localparam int FRM_LO  = TAG_W + 1;
    localparam int TOT_LO  = TAG_W + FRAME_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_DECODE    = 14'b00000000000010,
        ST_SCAN_RD   = 14'b00000000000100,
        ST_SCAN_CMP  = 14'b00000000001000,
        ST_FIN_RD    = 14'b00000000010000,
        ST_FIN_LATCH = 14'b00000000100000,
        ST_EMIT_DONE = 14'b00000001000000,
        ST_EMIT_FIN  = 14'b00000010000000,
        ST_GRANT     = 14'b00000100000000,
        ST_TICK_SEEK = 14'b00001000000000,
        ST_TICK_LOAD = 14'b00010000000000,
        ST_DIV       = 14'b00100000000000,
        ST_EMIT_PROG = 14'b01000000000000,
        ST_TICK_NEXT = 14'b10000000000000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [SLOTS-1:0]      busy_reg, busy_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [FRAME_BITS-1:0] best_frame_reg, best_frame_next;
    logic [TAG_W-1:0]      cur_tag_reg, cur_tag_next;
    logic                  cur_notify_reg, cur_notify_next;
    logic                  out_valid_reg, out_valid_next;
    evt_t                  out_data_reg, out_data_next;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [FRAME_BITS-1:0] rd_total, rd_frame, frame_inc, total_new;
    logic [TAG_W-1:0]      rd_tag;
    logic                  rd_notify;

    logic                  div_start, div_done;
    logic [Q_FRAC-1:0]     div_quot;

    logic                  free_any;
    logic [IDX_W-1:0]      free_idx;
    logic                  sel_ok;
    logic [IDX_W-1:0]      sel_idx;
    logic                  more_above;
    logic                  is_start, is_tick, tail;
    state_t                after_state;
    logic                  out_free, emit;
    evt_t                  emit_data;

    // slot memory, one write and one registered read per cycle; a tick writes slot i
    // before slot i+1 is read, so accesses to one entry never overlap
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rd_notify = rd_data_reg[0];
    assign rd_tag    = rd_data_reg[TAG_LO +: TAG_W];
    assign rd_frame  = rd_data_reg[FRM_LO +: FRAME_BITS];
    assign rd_total  = rd_data_reg[TOT_LO +: FRAME_BITS];
    assign frame_inc = rd_frame + 1'b1;
    assign total_new = FRAME_BITS'(cmd_reg.frame_count);

    fts_divider #(
        .FRAME_BITS (FRAME_BITS),
        .Q_BITS     (Q_FRAC)
    ) u_fts_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (frame_inc),
        .denom (rd_total),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign sel_ok     = 32'(cmd_reg.slot) < SLOTS;
    assign sel_idx    = IDX_W'(cmd_reg.slot);
    assign more_above = |((busy_reg >> idx_reg) >> 1);
    assign is_start   = kind_t'(cmd_reg.kind) == KIND_START;
    assign is_tick    = kind_t'(cmd_reg.kind) == KIND_TICK;
    assign tail       = is_start || (is_tick && more_above);
    assign after_state = is_start ? ST_GRANT : (is_tick ? ST_TICK_NEXT : ST_IDLE);
    assign out_free   = !out_valid_reg || evt.ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        pick_next       = pick_reg;
        best_frame_next = best_frame_reg;
        cur_tag_next    = cur_tag_reg;
        cur_notify_next = cur_notify_reg;
        mem_we          = 1'b0;
        mem_waddr       = pick_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        div_start       = 1'b0;
        emit            = 1'b0;
        emit_data       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (kind_t'(cmd_reg.kind))
                    KIND_START:
                    begin
                        if (free_any)
                        begin
                            pick_next  = free_idx;
                            state_next = ST_GRANT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                    end
                    KIND_TICK:
                    begin
                        idx_next   = '0;
                        state_next = ST_TICK_SEEK;
                    end
                    KIND_STOP:
                    begin
                        if (sel_ok && busy_reg[sel_idx])
                        begin
                            busy_next[sel_idx] = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                    KIND_FINISH:
                    begin
                        if (sel_ok && busy_reg[sel_idx])
                        begin
                            pick_next  = sel_idx;
                            state_next = ST_FIN_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                // greatest frame count, lowest index on ties
                if (idx_reg == '0 || rd_frame > best_frame_reg)
                begin
                    best_frame_next = rd_frame;
                    pick_next       = idx_reg;
                    cur_tag_next    = rd_tag;
                    cur_notify_next = rd_notify;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FIN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pick_reg;
                state_next = ST_FIN_LATCH;
            end
            ST_FIN_LATCH:
            begin
                cur_tag_next    = rd_tag;
                cur_notify_next = rd_notify;
                state_next      = ST_EMIT_DONE;
            end
            ST_EMIT_DONE:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.event_res  = EV_PROGRESS;
                    emit_data.slot_index = SLOT_W'(pick_reg);
                    emit_data.owner_tag  = cur_tag_reg;
                    emit_data.progress   = PROG_ONE;
                    emit_data.last       = !cur_notify_reg && !tail;
                    busy_next[pick_reg]  = 1'b0;
                    state_next           = cur_notify_reg ? ST_EMIT_FIN : after_state;
                end
            end
            ST_EMIT_FIN:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.event_res  = EV_FINISHED;
                    emit_data.slot_index = SLOT_W'(pick_reg);
                    emit_data.owner_tag  = cur_tag_reg;
                    emit_data.progress   = PROG_ONE;
                    emit_data.last       = !tail;
                    state_next           = after_state;
                end
            end
            ST_GRANT:
            begin
                if (out_free)
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = pick_reg;
                    mem_wdata            = {total_new, {FRAME_BITS{1'b0}}, cmd_reg.tag,
                                            cmd_reg.notify_on_finish};
                    busy_next[pick_reg]  = total_new != '0;
                    emit                 = 1'b1;
                    emit_data.event_res  = EV_GRANT;
                    emit_data.slot_index = SLOT_W'(pick_reg);
                    emit_data.owner_tag  = cmd_reg.tag;
                    emit_data.progress   = '0;
                    emit_data.last       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_TICK_SEEK:
            begin
                if (busy_reg[idx_reg])
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg;
                    state_next = ST_TICK_LOAD;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TICK_LOAD:
            begin
                cur_tag_next    = rd_tag;
                cur_notify_next = rd_notify;
                pick_next       = idx_reg;
                mem_we          = 1'b1;
                mem_waddr       = idx_reg;
                mem_wdata       = {rd_total, frame_inc, rd_tag, rd_notify};
                if (frame_inc >= rd_total)
                begin
                    state_next = ST_EMIT_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT_PROG;
                end
            end
            ST_EMIT_PROG:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_data.event_res  = EV_PROGRESS;
                    emit_data.slot_index = SLOT_W'(idx_reg);
                    emit_data.owner_tag  = cur_tag_reg;
                    emit_data.progress   = {1'b0, div_quot};
                    emit_data.last       = !more_above;
                    state_next           = ST_TICK_NEXT;
                end
            end
            ST_TICK_NEXT:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_SEEK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            busy_reg       <= '0;
            idx_reg        <= '0;
            pick_reg       <= '0;
            best_frame_reg <= '0;
            cur_tag_reg    <= '0;
            cur_notify_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            pick_reg       <= pick_next;
            best_frame_reg <= best_frame_next;
            cur_tag_reg    <= cur_tag_next;
            cur_notify_reg <= cur_notify_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign cmd.ready = state_reg == ST_IDLE;
    assign evt.valid = out_valid_reg;
    assign evt.data  = out_data_reg;

endmodule

@@ design/fts_checker.sv @@
// port checker for the frame tween slot manager and its bind
`include "frame_tween_slot_manager_defines.svh"

module fts_checker import fts_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic evt_valid,
    input logic evt_ready,
    input evt_t evt_data
);

    logic evt_stall;
    logic grant_seen, grant_ok;
    logic fin_seen, fin_ok;
    logic cmd_xfer;

    assign evt_stall  = evt_valid && !evt_ready;
    assign grant_seen = evt_valid && evt_data.event_res == EV_GRANT;
    assign grant_ok   = evt_data.last && evt_data.progress == '0;
    assign fin_seen   = evt_valid && evt_data.event_res == EV_FINISHED;
    assign fin_ok     = evt_data.progress == PROG_ONE;
    assign cmd_xfer   = cmd_valid && cmd_ready;

    `FTS_ASSERT_NEXT(a_evt_hold, clk, rst_n, evt_stall, evt_valid, "result dropped while stalled")
    `FTS_ASSERT_NEXT(a_evt_stable, clk, rst_n, evt_stall, $stable(evt_data), "result changed")
    `FTS_ASSERT_SAME(a_grant_form, clk, rst_n, grant_seen, grant_ok, "malformed grant")
    `FTS_ASSERT_SAME(a_finished_one, clk, rst_n, fin_seen, fin_ok, "finished without full progress")
    `FTS_ASSERT_NEXT(a_one_item, clk, rst_n, cmd_xfer, !cmd_ready, "second transfer while busy")

endmodule

bind frame_tween_slot_manager fts_checker u_fts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_data  (evt.data)
);
